// ===== rtl/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants of the timed event scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int DEF_SLOTS    = 64;
    localparam int DEF_TAG_BITS = 16;
    localparam int RESULT_CAP   = 64;
    localparam int CNT_W        = $clog2(RESULT_CAP);

    typedef enum logic [2:0] {
        F_ADD   = 3'd0,
        F_DEL   = 3'd1,
        F_TICK  = 3'd2,
        F_REARM = 3'd3,
        F_QUERY = 3'd4,
        F_WAIT  = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] delay_ms;
        logic               use_result_period;
        logic [15:0]        handler_tag;
        logic [30:0]        event_id;
        logic signed [31:0] handler_result;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] event_id_res;
        logic [15:0] handler_tag_res;
        logic [30:0] remaining_ms;
        logic        last;
    } t_res;

    // One stored event, tag kept in its own array
    typedef struct packed {
        logic [30:0] id;
        logic [31:0] due;
        logic [31:0] period;
        logic        mode;
        logic [31:0] order;
    } t_slot;

    typedef struct packed {
        logic load;
        logic rescan;
        logic finish;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic again;
        logic flush;
    } t_sts;

endpackage

// ===== rtl/tes_ctrl.sv =====
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer: accept a request, run slot scans, finish and flush results.
// ----------------------------------------------------------------------------
module tes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [2:0]    i_func,
    input  tes_pkg::t_sts i_sts,
    output tes_pkg::t_cmd o_cmd,
    output logic          busy
);
    import tes_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                // undefined codes are taken and dropped
                if (start && i_func <= F_WAIT) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_sts.again) begin
                    o_cmd.rescan = 1'b1;
                    n_state      = S_SCAN;
                end else if (i_sts.flush) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/tes_dpath.sv =====
// ----------------------------------------------------------------------------
// tes_dpath
// Slot store, scan pipeline, best-entry tracking and result register.
// ----------------------------------------------------------------------------
module tes_dpath #(
    parameter int SLOTS    = tes_pkg::DEF_SLOTS,
    parameter int TAG_BITS = tes_pkg::DEF_TAG_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tes_pkg::t_req i_req,
    input  tes_pkg::t_cmd i_cmd,
    output tes_pkg::t_sts o_sts,
    output logic          o_res_valid,
    output tes_pkg::t_res o_res
);
    import tes_pkg::*;

    localparam int IW = $clog2(SLOTS);

    t_slot               mem     [SLOTS];
    logic [TAG_BITS-1:0] tag_mem [SLOTS];

    t_req                r_req;
    logic                r_rd_act;
    logic [IW-1:0]       r_rd_idx;
    logic                r_chk_vld;
    logic [IW-1:0]       r_chk_idx;
    t_slot               r_rd_word;
    logic [TAG_BITS-1:0] r_rd_tag;
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_pend;
    logic [31:0]         r_now;
    logic [30:0]         r_next_id;
    logic [31:0]         r_order;
    logic                r_found;
    logic [IW-1:0]       r_best_idx;
    t_slot               r_best;
    logic [TAG_BITS-1:0] r_best_tag;
    logic [31:0]         r_best_da;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_held_vld;
    logic [30:0]         r_held_id;
    logic [15:0]         r_held_tag;
    logic                r_out_vld;
    t_res                r_out;

    logic [31:0]          da_c;
    logic                 before_c;
    logic                 cand;
    logic                 ranked;
    logic                 take;
    logic                 id_hit;
    logic [31:0]          addend;
    logic signed [33:0]   sum;
    logic [31:0]          clamp;
    logic [31:0]          new_due;
    logic [30:0]          left;
    logic [TAG_BITS+15:0] tag_in_ext;
    logic [TAG_BITS+15:0] tag_out_ext;
    logic [31:0]          ord_diff;
    logic                 is_tick;
    logic                 at_cap;

    assign da_c     = r_rd_word.due - r_now;
    assign ord_diff = r_rd_word.order - r_best.order;
    assign before_c = ($signed(da_c) < $signed(r_best_da))
                   || (da_c == r_best_da && ord_diff[31]);
    assign id_hit   = r_rd_word.id == r_req.event_id;
    assign ranked   = r_req.func == F_TICK || r_req.func == F_WAIT;

    always_comb begin
        case (r_req.func)
            F_ADD:   cand = !r_valid[r_chk_idx];
            F_DEL,
            F_QUERY: cand = r_valid[r_chk_idx] && !r_pend[r_chk_idx] && id_hit;
            F_REARM: cand = r_valid[r_chk_idx] && r_pend[r_chk_idx] && id_hit;
            F_TICK:  cand = r_valid[r_chk_idx] && !r_pend[r_chk_idx]
                         && $signed(da_c) <= 0;
            F_WAIT:  cand = r_valid[r_chk_idx] && !r_pend[r_chk_idx];
            default: cand = 1'b0;
        endcase
    end

    assign take = r_chk_vld && cand && (!r_found || (ranked && before_c));

    // reschedule: old distance plus period (or handler result when mode is set), saturated to [0, 2^31-1]
    assign addend = r_best.mode ? r_req.handler_result : r_best.period;
    assign sum    = {{2{r_best_da[31]}}, r_best_da} + {{2{addend[31]}}, addend};
    always_comb begin
        if (sum[33]) begin
            clamp = '0;
        end else if (sum[32:31] != 2'b00) begin
            clamp = 32'h7FFF_FFFF;
        end else begin
            clamp = sum[31:0];
        end
    end
    assign new_due = r_now + clamp;
    assign left    = r_best_da[31] ? '0 : r_best_da[30:0];

    assign tag_in_ext  = {{TAG_BITS{1'b0}}, r_req.handler_tag};
    assign tag_out_ext = {16'b0, r_best_tag};

    assign is_tick     = r_req.func == F_TICK;
    assign at_cap      = r_cnt == CNT_W'(RESULT_CAP - 1);
    assign o_sts.done  = r_chk_vld && r_chk_idx == IW'(SLOTS - 1);
    assign o_sts.again = is_tick && r_found && !at_cap;
    assign o_sts.flush = is_tick && r_found && at_cap;

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act   <= 1'b0;
            r_rd_idx   <= '0;
            r_chk_vld  <= 1'b0;
            r_valid    <= '0;
            r_pend     <= '0;
            r_now      <= '0;
            r_next_id  <= 31'd1;
            r_order    <= '0;
            r_found    <= 1'b0;
            r_cnt      <= '0;
            r_held_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            r_chk_vld <= r_rd_act;
            if (r_rd_act) begin
                if (r_rd_idx == IW'(SLOTS - 1)) begin
                    r_rd_act <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load) begin
                r_rd_act   <= 1'b1;
                r_rd_idx   <= '0;
                r_found    <= 1'b0;
                r_cnt      <= '0;
                r_held_vld <= 1'b0;
                if (i_req.func == F_TICK) begin
                    r_now <= r_now + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                case (r_req.func)
                    F_ADD: begin
                        r_out_vld <= 1'b1;
                        if (r_req.delay_ms != 0 && r_found) begin
                            r_valid[r_best_idx] <= 1'b1;
                            r_pend[r_best_idx]  <= 1'b0;
                            r_order             <= r_order + 1'b1;
                            r_next_id <= (r_next_id == 31'h7FFF_FFFF) ? 31'd1
                                                                       : r_next_id + 1'b1;
                        end
                    end
                    F_DEL: begin
                        r_out_vld <= 1'b1;
                        if (r_found) begin
                            r_valid[r_best_idx] <= 1'b0;
                        end
                    end
                    F_REARM: begin
                        r_out_vld <= 1'b1;
                        if (r_found) begin
                            r_pend[r_best_idx] <= 1'b0;
                            if (r_req.handler_result == 0) begin
                                r_valid[r_best_idx] <= 1'b0;
                            end else begin
                                r_order <= r_order + 1'b1;
                            end
                        end
                    end
                    F_TICK: begin
                        if (r_found) begin
                            r_pend[r_best_idx] <= 1'b1;
                            r_held_vld         <= 1'b1;
                            r_cnt              <= r_cnt + 1'b1;
                            r_out_vld          <= r_held_vld;
                        end else begin
                            r_out_vld  <= r_held_vld;
                            r_held_vld <= 1'b0;
                        end
                    end
                    F_QUERY, F_WAIT: r_out_vld <= 1'b1;
                    default: r_out_vld <= 1'b0;
                endcase
            end
            if (i_cmd.rescan) begin
                r_rd_act <= 1'b1;
                r_rd_idx <= '0;
                r_found  <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_out_vld  <= 1'b1;
                r_held_vld <= 1'b0;
            end
        end
    end

    // payload and slot store
    always_ff @(posedge i_clk) begin
        r_rd_word <= mem[r_rd_idx];
        r_rd_tag  <= tag_mem[r_rd_idx];
        r_chk_idx <= r_rd_idx;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (take) begin
            r_best_idx <= r_chk_idx;
            r_best     <= r_rd_word;
            r_best_tag <= r_rd_tag;
            r_best_da  <= da_c;
        end
        if (i_cmd.finish) begin
            r_out      <= '0;
            r_out.last <= 1'b1;
            case (r_req.func)
                F_ADD: begin
                    if (r_req.delay_ms == 0) begin
                        r_out.status <= ST_ZERO;
                    end else if (!r_found) begin
                        r_out.status <= ST_FULL;
                    end else begin
                        r_out.status       <= ST_OK;
                        r_out.event_id_res <= r_next_id;
                        mem[r_best_idx] <= '{
                            id:     r_next_id,
                            due:    r_req.delay_ms[31] ? r_now
                                                       : r_now + r_req.delay_ms,
                            period: r_req.delay_ms,
                            mode:   r_req.use_result_period,
                            order:  r_order
                        };
                        tag_mem[r_best_idx] <= tag_in_ext[TAG_BITS-1:0];
                    end
                end
                F_DEL: begin
                    r_out.status <= r_found ? ST_OK : ST_NOTFOUND;
                end
                F_REARM: begin
                    r_out.status <= r_found ? ST_OK : ST_NOTFOUND;
                    if (r_found && r_req.handler_result != 0) begin
                        mem[r_best_idx] <= '{
                            id:     r_best.id,
                            due:    new_due,
                            period: r_best.period,
                            mode:   r_best.mode,
                            order:  r_order
                        };
                    end
                end
                F_QUERY: begin
                    r_out.status <= r_found ? ST_OK : ST_NOTFOUND;
                    if (r_found) begin
                        r_out.remaining_ms <= left;
                    end
                end
                F_WAIT: begin
                    r_out.status <= r_found ? ST_OK : ST_EMPTY;
                    if (r_found) begin
                        r_out.remaining_ms <= left;
                    end
                end
                F_TICK: begin
                    // emit the held entry; last only when nothing more is due
                    r_out.status          <= ST_EXPIRED;
                    r_out.event_id_res    <= r_held_id;
                    r_out.handler_tag_res <= r_held_tag;
                    r_out.last            <= !r_found;
                    if (r_found) begin
                        r_held_id  <= r_best.id;
                        r_held_tag <= tag_out_ext[15:0];
                    end
                end
                default: r_out <= '0;
            endcase
        end
        if (i_cmd.flush) begin
            r_out                 <= '0;
            r_out.status          <= ST_EXPIRED;
            r_out.event_id_res    <= r_held_id;
            r_out.handler_tag_res <= r_held_tag;
            r_out.last            <= 1'b1;
        end
    end

endmodule

// ===== rtl/timed_event_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// timed_event_scheduler_top
// Queue of timed events on a millisecond clock with add, delete, tick,
// rearm, query and wait requests.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        i_req  (t_req)
// result    out        o_res_valid strobe   o_res  (t_res)
//
// Every request runs a scan over the slot store through the single read
// port, then a finish step; busy drops in the cycle the result is strobed.
// A tick rescans once per expired event until the result cap of 64 is
// reached, and then flushes the last held entry.
// Reset empties the queue at once; no clearing pass is needed.
// Results are strobed for one cycle each and the receiver cannot stall.
// ----------------------------------------------------------------------------
module timed_event_scheduler_top #(
    parameter int SLOTS    = tes_pkg::DEF_SLOTS,
    parameter int TAG_BITS = tes_pkg::DEF_TAG_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  tes_pkg::t_req i_req,
    output logic          busy,
    output logic          o_res_valid,
    output tes_pkg::t_res o_res
);
    import tes_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_req.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    tes_dpath #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
